[rtl/hte_pkg.sv]
// ----------------------------------------------------------------------------
// hte_pkg
// Shared types, constants and helpers of the heightmap thermal erosion block.
// ----------------------------------------------------------------------------
package hte_pkg;

    localparam int MAP_DIM   = 256;
    localparam int COORD_W   = $clog2(MAP_DIM);
    localparam int ADDR_W    = 2 * COORD_W;
    localparam int HEIGHT_W  = 16;
    localparam int PADDR_W   = 5;

    localparam logic [2:0] REG_MAP_WIDTH  = 3'd0;
    localparam logic [2:0] REG_MAP_DEPTH  = 3'd1;
    localparam logic [2:0] REG_RADIUS_Q4  = 3'd2;
    localparam logic [2:0] REG_TALUS      = 3'd3;
    localparam logic [2:0] REG_ITERATIONS = 3'd4;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_ERODE = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_RDWAIT,
        ST_CELL,
        ST_HGET,
        ST_NRD,
        ST_NEVAL,
        ST_NWR,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        MEM_IDLE,
        MEM_WR_CELL,
        MEM_RD_CELL,
        MEM_RD_CENTER,
        MEM_RD_NB,
        MEM_WR_CENTER,
        MEM_WR_NB
    } mem_op_t;

    typedef struct packed {
        logic [8:0] map_width;
        logic [8:0] map_depth;
        logic [9:0] radius_q4;
        logic [9:0] talus;
        logic [6:0] iterations;
    } cfg_t;

    typedef struct packed {
        mem_op_t mem_op;
        logic    latch_in;
        logic    erode_init;
        logic    load_read;
        logic    h_load;
        logic    k_clr;
        logic    k_inc;
        logic    cell_adv;
        logic    set_changed;
    } dp_ctrl_t;

    typedef struct packed {
        cmd_t cmd;
        logic cell_ok;
        logic move;
        logic k_last;
        logic all_last;
    } dp_stat_t;

    // neighbour offsets in row order, skipping the centre
    function automatic logic [COORD_W-1:0] nb_dx(input logic [2:0] k);
        logic [COORD_W-1:0] v;
        unique case (k)
            3'd0, 3'd3, 3'd5: v = '1;
            3'd1, 3'd6:       v = '0;
            default:          v = COORD_W'(1);
        endcase
        return v;
    endfunction

    function automatic logic [COORD_W-1:0] nb_dz(input logic [2:0] k);
        logic [COORD_W-1:0] v;
        unique case (k)
            3'd0, 3'd1, 3'd2: v = '1;
            3'd3, 3'd4:       v = '0;
            default:          v = COORD_W'(1);
        endcase
        return v;
    endfunction

endpackage

[rtl/hte_cfg.sv]
// ----------------------------------------------------------------------------
// hte_cfg
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module hte_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hte_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output hte_pkg::cfg_t                 cfg
);

    hte_pkg::cfg_t cfg_reg;
    hte_pkg::cfg_t cfg_next;
    logic [2:0]    idx;

    assign idx    = paddr[4:2];
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite)
        begin
            unique case (idx)
                hte_pkg::REG_MAP_WIDTH:  cfg_next.map_width  = pwdata[8:0];
                hte_pkg::REG_MAP_DEPTH:  cfg_next.map_depth  = pwdata[8:0];
                hte_pkg::REG_RADIUS_Q4:  cfg_next.radius_q4  = pwdata[9:0];
                hte_pkg::REG_TALUS:      cfg_next.talus      = pwdata[9:0];
                hte_pkg::REG_ITERATIONS: cfg_next.iterations = pwdata[6:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            hte_pkg::REG_MAP_WIDTH:  prdata = {23'd0, cfg_reg.map_width};
            hte_pkg::REG_MAP_DEPTH:  prdata = {23'd0, cfg_reg.map_depth};
            hte_pkg::REG_RADIUS_Q4:  prdata = {22'd0, cfg_reg.radius_q4};
            hte_pkg::REG_TALUS:      prdata = {22'd0, cfg_reg.talus};
            hte_pkg::REG_ITERATIONS: prdata = {25'd0, cfg_reg.iterations};
            default:                 prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.map_width  <= 9'd256;
            cfg_reg.map_depth  <= 9'd256;
            cfg_reg.radius_q4  <= 10'd64;
            cfg_reg.talus      <= 10'd400;
            cfg_reg.iterations <= 7'd1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[rtl/hte_ctrl.sv]
// ----------------------------------------------------------------------------
// hte_ctrl
// Command sequencer: dispatches transactions and walks the erosion scan.
// ----------------------------------------------------------------------------
module hte_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    output logic                done,
    input  hte_pkg::dp_stat_t   stat,
    output hte_pkg::dp_ctrl_t   ctrl
);

    hte_pkg::state_t state_reg;
    hte_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= hte_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != hte_pkg::ST_IDLE);
    assign done = (state_reg == hte_pkg::ST_DONE);

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        ctrl.mem_op = hte_pkg::MEM_IDLE;
        unique case (state_reg)
            hte_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    ctrl.latch_in = 1'b1;
                    state_next    = hte_pkg::ST_DISPATCH;
                end
            end
            hte_pkg::ST_DISPATCH:
            begin
                unique case (stat.cmd)
                    hte_pkg::CMD_WRITE:
                    begin
                        ctrl.mem_op = hte_pkg::MEM_WR_CELL;
                        state_next  = hte_pkg::ST_DONE;
                    end
                    hte_pkg::CMD_READ:
                    begin
                        ctrl.mem_op = hte_pkg::MEM_RD_CELL;
                        state_next  = hte_pkg::ST_RDWAIT;
                    end
                    hte_pkg::CMD_ERODE:
                    begin
                        ctrl.erode_init = 1'b1;
                        state_next      = hte_pkg::ST_CELL;
                    end
                    default:
                        state_next = hte_pkg::ST_DONE;
                endcase
            end
            hte_pkg::ST_RDWAIT:
            begin
                ctrl.load_read = 1'b1;
                state_next     = hte_pkg::ST_DONE;
            end
            hte_pkg::ST_CELL:
            begin
                if (stat.cell_ok)
                begin
                    ctrl.mem_op = hte_pkg::MEM_RD_CENTER;
                    ctrl.k_clr  = 1'b1;
                    state_next  = hte_pkg::ST_HGET;
                end
                else if (stat.all_last)
                    state_next = hte_pkg::ST_DONE;
                else
                    ctrl.cell_adv = 1'b1;
            end
            hte_pkg::ST_HGET:
            begin
                ctrl.h_load = 1'b1;
                state_next  = hte_pkg::ST_NRD;
            end
            hte_pkg::ST_NRD:
            begin
                ctrl.mem_op = hte_pkg::MEM_RD_NB;
                state_next  = hte_pkg::ST_NEVAL;
            end
            hte_pkg::ST_NEVAL, hte_pkg::ST_NWR:
            begin
                if (state_reg == hte_pkg::ST_NEVAL && stat.move)
                begin
                    ctrl.mem_op      = hte_pkg::MEM_WR_CENTER;
                    ctrl.set_changed = 1'b1;
                    state_next       = hte_pkg::ST_NWR;
                end
                else
                begin
                    if (state_reg == hte_pkg::ST_NWR)
                        ctrl.mem_op = hte_pkg::MEM_WR_NB;
                    if (!stat.k_last)
                    begin
                        ctrl.k_inc = 1'b1;
                        state_next = hte_pkg::ST_NRD;
                    end
                    else if (stat.all_last)
                        state_next = hte_pkg::ST_DONE;
                    else
                    begin
                        ctrl.cell_adv = 1'b1;
                        state_next    = hte_pkg::ST_CELL;
                    end
                end
            end
            hte_pkg::ST_DONE:
                state_next = hte_pkg::ST_IDLE;
            default:
                state_next = hte_pkg::ST_IDLE;
        endcase
    end

endmodule

[rtl/hte_dp.sv]
// ----------------------------------------------------------------------------
// hte_dp
// Datapath: height store, scan counters, talus compare and result registers.
// ----------------------------------------------------------------------------
module hte_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  hte_pkg::cfg_t                   cfg,
    input  logic [1:0]                      command,
    input  logic [hte_pkg::COORD_W-1:0]     x_pos,
    input  logic [hte_pkg::COORD_W-1:0]     z_pos,
    input  logic [hte_pkg::HEIGHT_W-1:0]    write_height,
    input  hte_pkg::dp_ctrl_t               ctrl,
    output hte_pkg::dp_stat_t               stat,
    output logic [hte_pkg::HEIGHT_W-1:0]    read_height,
    output logic                            changed
);

    localparam int CW = hte_pkg::COORD_W;
    localparam int HW = hte_pkg::HEIGHT_W;
    localparam int AW = hte_pkg::ADDR_W;

    logic [HW-1:0]         mem [hte_pkg::MAP_DIM*hte_pkg::MAP_DIM];
    logic [HW-1:0]         rdata_reg;

    hte_pkg::cmd_t         cmd_reg;
    logic [CW-1:0]         cx_reg;
    logic [CW-1:0]         cz_reg;
    logic [HW-1:0]         wh_reg;
    logic [6:0]            r_reg;
    logic [19:0]           r2_reg;
    logic [6:0]            passes_reg;
    logic [6:0]            it_reg;
    logic signed [10:0]    x_reg;
    logic signed [10:0]    z_reg;
    logic [2:0]            k_reg;
    logic [HW-1:0]         h_reg;
    logic [HW-1:0]         rh_reg;
    logic                  chg_reg;

    logic [8:0]            w_eff;
    logic [8:0]            d_eff;
    logic                  in_map;
    logic signed [10:0]    cx_s;
    logic signed [10:0]    cz_s;
    logic signed [10:0]    r_s;
    logic signed [10:0]    dx;
    logic signed [10:0]    dz;
    logic signed [15:0]    dx2;
    logic signed [15:0]    dz2;
    logic [13:0]           dsq;
    logic                  in_radius;
    logic                  in_bounds;
    logic                  last_x;
    logic                  last_z;
    logic [CW-1:0]         nx;
    logic [CW-1:0]         nz;
    logic signed [16:0]    diff;
    logic signed [16:0]    excess;
    logic [HW-1:0]         mv;
    logic                  we;
    logic                  re;
    logic [AW-1:0]         addr;
    logic [HW-1:0]         wdata;

    assign w_eff  = (cfg.map_width > 9'(hte_pkg::MAP_DIM)) ? 9'(hte_pkg::MAP_DIM)
                                                           : cfg.map_width;
    assign d_eff  = (cfg.map_depth > 9'(hte_pkg::MAP_DIM)) ? 9'(hte_pkg::MAP_DIM)
                                                           : cfg.map_depth;
    assign in_map = ({1'b0, cx_reg} < w_eff) && ({1'b0, cz_reg} < d_eff);

    assign cx_s = $signed({3'd0, cx_reg});
    assign cz_s = $signed({3'd0, cz_reg});
    assign r_s  = $signed({4'd0, r_reg});
    assign dx   = x_reg - cx_s;
    assign dz   = z_reg - cz_s;
    assign dx2  = $signed(dx[7:0]) * $signed(dx[7:0]);
    assign dz2  = $signed(dz[7:0]) * $signed(dz[7:0]);
    assign dsq  = 14'(dx2[12:0]) + 14'(dz2[12:0]);
    assign in_radius = {dsq, 8'd0} < {2'd0, r2_reg};
    assign in_bounds = (x_reg > 11'sd0) && (z_reg > 11'sd0)
                    && (x_reg < $signed({2'd0, w_eff}) - 11'sd1)
                    && (z_reg < $signed({2'd0, d_eff}) - 11'sd1);
    assign last_x = (x_reg == cx_s + r_s);
    assign last_z = (z_reg == cz_s + r_s);

    assign nx     = x_reg[CW-1:0] + hte_pkg::nb_dx(k_reg);
    assign nz     = z_reg[CW-1:0] + hte_pkg::nb_dz(k_reg);
    assign diff   = $signed({1'b0, h_reg}) - $signed({1'b0, rdata_reg});
    assign excess = diff - $signed({7'd0, cfg.talus});
    assign mv     = excess[HW:1];

    assign stat.cmd      = cmd_reg;
    assign stat.cell_ok  = in_bounds && in_radius;
    assign stat.move     = diff > $signed({7'd0, cfg.talus});
    assign stat.k_last   = (k_reg == 3'd7);
    assign stat.all_last = last_x && last_z && (it_reg == passes_reg - 7'd1);

    assign read_height = rh_reg;
    assign changed     = chg_reg;

    always_comb
    begin
        we    = 1'b0;
        re    = 1'b0;
        addr  = {cz_reg, cx_reg};
        wdata = wh_reg;
        unique case (ctrl.mem_op)
            hte_pkg::MEM_WR_CELL:
                we = in_map;
            hte_pkg::MEM_RD_CELL:
                re = 1'b1;
            hte_pkg::MEM_RD_CENTER:
            begin
                re   = 1'b1;
                addr = {z_reg[CW-1:0], x_reg[CW-1:0]};
            end
            hte_pkg::MEM_RD_NB:
            begin
                re   = 1'b1;
                addr = {nz, nx};
            end
            hte_pkg::MEM_WR_CENTER:
            begin
                we    = 1'b1;
                addr  = {z_reg[CW-1:0], x_reg[CW-1:0]};
                wdata = h_reg - mv;
            end
            hte_pkg::MEM_WR_NB:
            begin
                we    = 1'b1;
                addr  = {nz, nx};
                wdata = rdata_reg + mv;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        if (re)
            rdata_reg <= mem[addr];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.latch_in)
        begin
            cmd_reg <= hte_pkg::cmd_t'(command);
            cx_reg  <= x_pos;
            cz_reg  <= z_pos;
            wh_reg  <= write_height;
        end
        if (ctrl.erode_init)
        begin
            r_reg      <= 7'((11'(cfg.radius_q4) + 11'd15) >> 4);
            r2_reg     <= cfg.radius_q4 * cfg.radius_q4;
            passes_reg <= (cfg.iterations == 7'd0) ? 7'd1 : cfg.iterations;
        end
        if (ctrl.h_load)
            h_reg <= rdata_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            it_reg  <= '0;
            x_reg   <= '0;
            z_reg   <= '0;
            k_reg   <= '0;
            rh_reg  <= '0;
            chg_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.latch_in)
            begin
                rh_reg  <= '0;
                chg_reg <= 1'b0;
            end
            if (ctrl.load_read && in_map)
                rh_reg <= rdata_reg;
            if (ctrl.set_changed)
                chg_reg <= 1'b1;
            if (ctrl.erode_init)
            begin
                it_reg <= '0;
                x_reg  <= cx_s - $signed({4'd0, 7'((11'(cfg.radius_q4) + 11'd15) >> 4)});
                z_reg  <= cz_s - $signed({4'd0, 7'((11'(cfg.radius_q4) + 11'd15) >> 4)});
            end
            if (ctrl.cell_adv)
            begin
                if (last_x)
                begin
                    x_reg <= cx_s - r_s;
                    if (last_z)
                    begin
                        z_reg  <= cz_s - r_s;
                        it_reg <= it_reg + 7'd1;
                    end
                    else
                        z_reg <= z_reg + 11'sd1;
                end
                else
                    x_reg <= x_reg + 11'sd1;
            end
            if (ctrl.k_clr)
                k_reg <= '0;
            else if (ctrl.k_inc)
                k_reg <= k_reg + 3'd1;
        end
    end

endmodule

[rtl/heightmap_thermal_erosion.sv]
// ----------------------------------------------------------------------------
// heightmap_thermal_erosion
// Heightmap store with cell write/read and talus-driven thermal erosion.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------------
//   command  | start & !busy        | command, x_pos, z_pos, write_height
//   result   | done (one cycle)     | read_height, changed
//   config   | psel&penable&pwrite  | paddr, pwdata, prdata
//
// Write and unused commands go through dispatch to done; read adds a wait for the
// registered read (single-port store). Erode scans each position per pass,
// reads a visited cell's centre, then each neighbour, writing both back when
// the talus is exceeded. Reset clears control and config, not the store.
// The receiver cannot stall: done is asserted for one cycle only.
// ----------------------------------------------------------------------------
module heightmap_thermal_erosion (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    output logic                            done,
    input  logic [1:0]                      command,
    input  logic [hte_pkg::COORD_W-1:0]     x_pos,
    input  logic [hte_pkg::COORD_W-1:0]     z_pos,
    input  logic [hte_pkg::HEIGHT_W-1:0]    write_height,
    output logic [hte_pkg::HEIGHT_W-1:0]    read_height,
    output logic                            changed,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [hte_pkg::PADDR_W-1:0]     paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    hte_pkg::cfg_t     cfg;
    hte_pkg::dp_ctrl_t ctrl;
    hte_pkg::dp_stat_t stat;

    hte_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hte_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    hte_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .command      (command),
        .x_pos        (x_pos),
        .z_pos        (z_pos),
        .write_height (write_height),
        .ctrl         (ctrl),
        .stat         (stat),
        .read_height  (read_height),
        .changed      (changed)
    );

endmodule

[rtl/hte_checker.sv]
// ----------------------------------------------------------------------------
// hte_checker
// Port-level checks of the command/result sequencing and of pready, bound to the top level.
// ----------------------------------------------------------------------------
module hte_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        done,
    input  logic [15:0] read_height,
    input  logic        changed,
    input  logic        pready
);

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe outside a transaction");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done && !busy)
        else $error("result strobe longer than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted transaction did not raise busy");

    a_fields_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(changed && (read_height != 16'd0)))
        else $error("read height and changed flag both set");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind heightmap_thermal_erosion hte_checker u_hte_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .read_height (read_height),
    .changed     (changed),
    .pready      (pready)
);
